[rtl/sta_pkg.sv]
// ----------------------------------------------------------------------------
// sta_pkg
// Shared types and constants for the section table address translator.
// ----------------------------------------------------------------------------
package sta_pkg;

    localparam int MAX_SECTIONS = 128;
    localparam int ADDR_W       = $clog2(MAX_SECTIONS);
    localparam int CNT_W        = $clog2(MAX_SECTIONS + 1);
    localparam int LABEL_BYTES  = 8;
    localparam int LABEL_W      = 8 * LABEL_BYTES;

    typedef enum logic [2:0] {
        CMD_WRITE = 3'd0,
        CMD_V2O   = 3'd1,
        CMD_O2V   = 3'd2,
        CMD_NAME  = 3'd3,
        CMD_SIZE  = 3'd4
    } sta_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } sta_state_t;

    typedef struct packed {
        logic [2:0]         command;
        logic [6:0]         entry_index;
        logic [31:0]        entry_virtual;
        logic [31:0]        entry_offset;
        logic [31:0]        entry_size;
        logic [LABEL_W-1:0] entry_label;
        logic [31:0]        query_address;
        logic [LABEL_W-1:0] query_label;
    } sta_req_t;

    typedef struct packed {
        logic [31:0] result_value;
        logic        found;
        logic [6:0]  matched_index;
    } sta_rsp_t;

    typedef struct packed {
        logic [31:0]        virt;
        logic [31:0]        offset;
        logic [31:0]        size;
        logic [LABEL_W-1:0] label;
    } sta_entry_t;

endpackage

[rtl/sta_engine.sv]
// ----------------------------------------------------------------------------
// sta_engine
// Section table memory and the scan sequencer that serves one request at a
// time: one table read issued per cycle, data evaluated the cycle after.
// ----------------------------------------------------------------------------
module sta_engine import sta_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [CNT_W-1:0] count,
    input  logic             req_valid,
    output logic             req_ready,
    input  sta_req_t         req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output sta_rsp_t         rsp
);

    sta_entry_t mem [MAX_SECTIONS];
    sta_entry_t rd_data_reg;
    sta_entry_t wr_data;
    logic       mem_we;
    logic [ADDR_W-1:0] wr_addr;

    sta_state_t        state_reg, state_next;
    logic [2:0]        cmd_reg, cmd_next;
    logic [31:0]       query_reg, query_next;
    logic [LABEL_W-1:0] qlabel_reg, qlabel_next;
    logic [CNT_W-1:0]  issue_cnt_reg, issue_cnt_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] pend_idx_reg, pend_idx_next;
    logic              hit_reg, hit_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [31:0]       value_reg, value_next;
    logic [31:0]       best_off_reg, best_off_next;
    logic [31:0]       best_size_reg, best_size_next;

    logic [CNT_W-1:0]  live;
    logic [CNT_W-1:0]  live_m1;
    logic              issue;
    logic              scan_down;
    logic              match;
    logic              done;
    logic [31:0]       match_value;

    // Writes happen only in idle and reads only in scan, so a read always
    // sees completed writes; no forwarding path is needed.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[addr_reg];
    end

    assign live    = (count > CNT_W'(MAX_SECTIONS)) ? CNT_W'(MAX_SECTIONS) : count;
    assign live_m1 = live - CNT_W'(1);

    assign wr_addr = req.entry_index[ADDR_W-1:0];
    assign wr_data = '{virt:   req.entry_virtual,
                       offset: req.entry_offset,
                       size:   req.entry_size,
                       label:  req.entry_label};

    assign scan_down = (cmd_reg == CMD_V2O) || (cmd_reg == CMD_O2V);
    assign issue     = (issue_cnt_reg != '0);

    always_comb begin
        match       = 1'b0;
        match_value = rd_data_reg.virt;
        case (cmd_reg)
            CMD_V2O: begin
                match       = (query_reg >= rd_data_reg.virt);
                match_value = rd_data_reg.offset + (query_reg - rd_data_reg.virt);
            end
            CMD_O2V: begin
                match       = (query_reg >= rd_data_reg.offset) && (rd_data_reg.size != '0);
                match_value = rd_data_reg.virt + (query_reg - rd_data_reg.offset);
            end
            CMD_NAME: begin
                match       = (rd_data_reg.label == qlabel_reg);
                match_value = rd_data_reg.virt;
            end
            default: begin
                match       = 1'b0;
                match_value = rd_data_reg.virt;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            issue_cnt_reg <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
        end else begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        query_reg     <= query_next;
        qlabel_reg    <= qlabel_next;
        addr_reg      <= addr_next;
        pend_idx_reg  <= pend_idx_next;
        idx_reg       <= idx_next;
        value_reg     <= value_next;
        best_off_reg  <= best_off_next;
        best_size_reg <= best_size_next;
    end

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        query_next     = query_reg;
        qlabel_next    = qlabel_reg;
        issue_cnt_next = issue_cnt_reg;
        addr_next      = addr_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        hit_next       = hit_reg;
        idx_next       = idx_reg;
        value_next     = value_reg;
        best_off_next  = best_off_reg;
        best_size_next = best_size_reg;
        mem_we         = 1'b0;
        done           = 1'b0;
        req_ready      = 1'b0;
        rsp_valid      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    cmd_next       = req.command;
                    query_next     = req.query_address;
                    qlabel_next    = req.query_label;
                    issue_cnt_next = live;
                    pend_next      = 1'b0;
                    hit_next       = 1'b0;
                    idx_next       = '0;
                    value_next     = '0;
                    best_off_next  = '0;
                    best_size_next = '0;
                    addr_next      = '0;
                    state_next     = ST_RESP;
                    case (req.command)
                        CMD_WRITE: begin
                            mem_we = (32'(req.entry_index) < MAX_SECTIONS);
                        end
                        CMD_V2O, CMD_O2V: begin
                            // backward scan from the last live entry
                            value_next = req.query_address;
                            addr_next  = live_m1[ADDR_W-1:0];
                            state_next = ST_SCAN;
                        end
                        CMD_NAME, CMD_SIZE: begin
                            state_next = ST_SCAN;
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                if (issue) begin
                    issue_cnt_next = issue_cnt_reg - CNT_W'(1);
                    addr_next      = scan_down ? addr_reg - ADDR_W'(1)
                                               : addr_reg + ADDR_W'(1);
                    pend_idx_next  = addr_reg;
                end
                if (pend_reg) begin
                    if (cmd_reg == CMD_SIZE) begin
                        // strict compare keeps the lowest index on a tie
                        if (!hit_reg || (rd_data_reg.offset > best_off_reg)) begin
                            hit_next       = 1'b1;
                            idx_next       = pend_idx_reg;
                            best_off_next  = rd_data_reg.offset;
                            best_size_next = rd_data_reg.size;
                        end
                    end else if (match) begin
                        hit_next   = 1'b1;
                        idx_next   = pend_idx_reg;
                        value_next = match_value;
                        done       = 1'b1;
                    end
                end
                if (!issue) begin
                    done = 1'b1;
                end
                pend_next = issue && !done;
                if (done) begin
                    state_next = ST_RESP;
                end
            end

            ST_RESP: begin
                rsp_valid = 1'b1;
                if (rsp_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp.result_value  = ((cmd_reg == CMD_SIZE) && hit_reg)
                               ? best_off_reg + best_size_reg : value_reg;
    assign rsp.found         = hit_reg;
    assign rsp.matched_index = idx_reg;

endmodule

[rtl/section_table_address_translator.sv]
// ----------------------------------------------------------------------------
// section_table_address_translator
// Section table with address translation, name lookup and image size queries.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  s_*       in         s_valid / s_ready     sta_req_t (command and operands)
//  m_*       out        m_valid / m_ready     sta_rsp_t (one result per request)
//  cfg_*     in         cfg_valid / cfg_ready section_count (8 bit)
//
// A query reads up to n table entries, n being the live section count (at
// most 128): the single table read port delivers one entry per cycle. Reset
// clears control state only; table contents are undefined until written. One
// request is worked on at a time; a result held on a stalled m_ready does not
// block the next request.
module section_table_address_translator import sta_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  sta_req_t   s_payload,
    output logic       m_valid,
    input  logic       m_ready,
    output sta_rsp_t   m_payload,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    logic [7:0] count_reg;
    logic       m_valid_reg;
    sta_rsp_t   m_payload_reg;
    logic       eng_rsp_valid;
    logic       eng_rsp_ready;
    sta_rsp_t   eng_rsp;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cfg_valid) begin
            count_reg <= cfg_data;
        end
    end

    sta_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .count     (CNT_W'(count_reg)),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req       (s_payload),
        .rsp_valid (eng_rsp_valid),
        .rsp_ready (eng_rsp_ready),
        .rsp       (eng_rsp)
    );

    // output register: takes a new result when empty or being drained
    assign eng_rsp_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (eng_rsp_valid && eng_rsp_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (eng_rsp_valid && eng_rsp_ready) begin
            m_payload_reg <= eng_rsp;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

[rtl/sta_checker.sv]
// ----------------------------------------------------------------------------
// sta_checker
// Port-level checks for the section table address translator.
// ----------------------------------------------------------------------------
module sta_checker import sta_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  logic     m_valid,
    input  logic     m_ready,
    input  sta_rsp_t m_payload
);

    // no result may appear out of reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("stalled result changed");

    // one request in the engine at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while engine busy");

    // a miss reports index zero
    a_miss_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_payload.found |-> m_payload.matched_index == '0)
        else $error("miss with nonzero matched index");

endmodule

bind section_table_address_translator sta_checker u_sta_checker (.*);

[tb/sta_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sta_scoreboard
// Watches the request, result and count channels of the section table address
// translator, keeps its own copy of the table and count, works out each
// result when a request is taken and compares it with what comes back.
// ----------------------------------------------------------------------------
module sta_scoreboard import sta_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  sta_req_t   s_payload,
    input  logic       m_valid,
    input  logic       m_ready,
    input  sta_rsp_t   m_payload,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [7:0] cfg_data,
    output int         mismatch_count,
    output int         rsp_outstanding
);

    logic [31:0]        virt_tab  [MAX_SECTIONS];
    logic [31:0]        off_tab   [MAX_SECTIONS];
    logic [31:0]        size_tab  [MAX_SECTIONS];
    logic [LABEL_W-1:0] label_tab [MAX_SECTIONS];
    logic [7:0]         cfg_sections;
    sta_rsp_t           rsp_due_q [$];

    // counts past the table depth behave as a full table
    function automatic int live_sections();
        return (cfg_sections > MAX_SECTIONS) ? MAX_SECTIONS : int'(cfg_sections);
    endfunction

    function automatic sta_rsp_t translate_request(input sta_req_t req);
        sta_rsp_t rsp;
        int       n;
        n   = live_sections();
        rsp = '0;
        case (req.command)
            CMD_V2O: begin
                rsp.result_value = req.query_address;
                for (int i = n - 1; i >= 0; i--) begin
                    if (!rsp.found && req.query_address >= virt_tab[i]) begin
                        rsp.result_value  = off_tab[i] + (req.query_address - virt_tab[i]);
                        rsp.found         = 1'b1;
                        rsp.matched_index = 7'(i);
                    end
                end
            end
            CMD_O2V: begin
                rsp.result_value = req.query_address;
                for (int i = n - 1; i >= 0; i--) begin
                    if (!rsp.found && req.query_address >= off_tab[i] && size_tab[i] != 0) begin
                        rsp.result_value  = virt_tab[i] + (req.query_address - off_tab[i]);
                        rsp.found         = 1'b1;
                        rsp.matched_index = 7'(i);
                    end
                end
            end
            CMD_NAME: begin
                for (int i = 0; i < n; i++) begin
                    if (!rsp.found && label_tab[i] == req.query_label) begin
                        rsp.result_value  = virt_tab[i];
                        rsp.found         = 1'b1;
                        rsp.matched_index = 7'(i);
                    end
                end
            end
            CMD_SIZE: begin
                // strict compare keeps the lowest index on equal offsets
                for (int i = 0; i < n; i++) begin
                    if (!rsp.found || off_tab[i] > off_tab[rsp.matched_index]) begin
                        rsp.found         = 1'b1;
                        rsp.matched_index = 7'(i);
                    end
                end
                if (rsp.found)
                    rsp.result_value = off_tab[rsp.matched_index] + size_tab[rsp.matched_index];
            end
            default: begin
                // writes and unused commands answer all zero
            end
        endcase
        return rsp;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        sta_rsp_t want;
        if (!aresetn) begin
            rsp_due_q.delete();
            cfg_sections   = '0;
            mismatch_count = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                cfg_sections = cfg_data;
            if (s_valid && s_ready) begin
                rsp_due_q.push_back(translate_request(s_payload));
                if (s_payload.command == CMD_WRITE) begin
                    virt_tab[s_payload.entry_index]  = s_payload.entry_virtual;
                    off_tab[s_payload.entry_index]   = s_payload.entry_offset;
                    size_tab[s_payload.entry_index]  = s_payload.entry_size;
                    label_tab[s_payload.entry_index] = s_payload.entry_label;
                end
            end
            if (m_valid && m_ready) begin
                if (rsp_due_q.size() == 0) begin
                    $display("%0t: result with no request waiting, got %h", $time, m_payload);
                    mismatch_count++;
                end else begin
                    want = rsp_due_q.pop_front();
                    check_field("result_value", want.result_value, m_payload.result_value);
                    check_field("found", 32'(want.found), 32'(m_payload.found));
                    check_field("matched_index", 32'(want.matched_index),
                                32'(m_payload.matched_index));
                end
            end
        end
        rsp_outstanding = rsp_due_q.size();
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the section table address translator with a directed opening, a
// full table load and phases of shaped random requests under varying back
// pressure and section counts; the scoreboard beside the block judges results.
// ----------------------------------------------------------------------------
module tb_top;
    import sta_pkg::*;

    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
    localparam int         STUCK_LIMIT     = 4000;
    localparam int         PHASES          = 12;
    localparam int         ITEMS_PER_PHASE = 52;
    localparam int         LABEL_POOL      = 6;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    sta_req_t   s_payload;
    logic       m_valid;
    logic       m_ready = 1'b0;
    sta_rsp_t   m_payload;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;
    int         mismatch_count;
    int         rsp_outstanding;
    int         stuck_cycles;
    int         send_idle_pct;
    int         recv_stall_pct;
    logic [7:0] section_count;

    // copy of what was written: aims queries at live entries, seeds duplicates
    logic [31:0]        sh_virt    [MAX_SECTIONS];
    logic [31:0]        sh_off     [MAX_SECTIONS];
    logic [LABEL_W-1:0] sh_label   [MAX_SECTIONS];
    logic [LABEL_W-1:0] label_pool [LABEL_POOL];

    section_table_address_translator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    sta_scoreboard u_scoreboard (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_payload       (s_payload),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload       (m_payload),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .rsp_outstanding (rsp_outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STUCK_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    function automatic int live_slot();
        int n;
        n = (section_count > MAX_SECTIONS) ? MAX_SECTIONS : int'(section_count);
        return (n == 0) ? $urandom_range(MAX_SECTIONS - 1, 0) : $urandom_range(n - 1, 0);
    endfunction

    function automatic sta_req_t random_req();
        sta_req_t req;
        req.command       = 3'($urandom);
        req.entry_index   = 7'($urandom);
        req.entry_virtual = $urandom;
        req.entry_offset  = $urandom;
        req.entry_size    = $urandom;
        req.entry_label   = {$urandom, $urandom};
        req.query_address = $urandom;
        req.query_label   = {$urandom, $urandom};
        return req;
    endfunction

    // clustered page-aligned values plus duplicates make ties and near hits
    function automatic logic [31:0] shaped_word(input logic [31:0] twin);
        case ($urandom_range(7, 0))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return $urandom;
            4, 5:    return $urandom_range(15, 0) << 12;
            6:       return twin;
            default: return 32'h8000_0000 | ($urandom_range(15, 0) << 12);
        endcase
    endfunction

    function automatic logic [31:0] shaped_size();
        case ($urandom_range(5, 0))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            default: return $urandom_range(16'h4000, 1);
        endcase
    endfunction

    function automatic logic [LABEL_W-1:0] shaped_label();
        case ($urandom_range(3, 0))
            0, 1:    return label_pool[$urandom_range(LABEL_POOL - 1, 0)];
            2:       return sh_label[$urandom_range(MAX_SECTIONS - 1, 0)];
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [31:0] aim_address(input logic [31:0] base);
        case ($urandom_range(5, 0))
            0:       return $urandom;
            1:       return $urandom_range(1, 0) ? 32'hFFFF_FFFF : 32'h0;
            2:       return base - $urandom_range(4, 1);
            3:       return base;
            default: return base + $urandom_range(16'hFFFF, 0);
        endcase
    endfunction

    function automatic logic [LABEL_W-1:0] aim_label();
        case ($urandom_range(4, 0))
            0, 1, 2: return sh_label[live_slot()];
            3:       return label_pool[$urandom_range(LABEL_POOL - 1, 0)];
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_req(input sta_req_t req);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic put_entry(input logic [6:0] idx, input logic [31:0] v, o, sz,
                             input logic [LABEL_W-1:0] lbl);
        sta_req_t req;
        req               = random_req();
        req.command       = CMD_WRITE;
        req.entry_index   = idx;
        req.entry_virtual = v;
        req.entry_offset  = o;
        req.entry_size    = sz;
        req.entry_label   = lbl;
        sh_virt[idx]      = v;
        sh_off[idx]       = o;
        sh_label[idx]     = lbl;
        send_req(req);
    endtask

    task automatic write_random_entry(input logic [6:0] idx);
        put_entry(idx, shaped_word(sh_virt[$urandom_range(MAX_SECTIONS - 1, 0)]),
                  shaped_word(sh_off[$urandom_range(MAX_SECTIONS - 1, 0)]),
                  shaped_size(), shaped_label());
    endtask

    task automatic ask(input logic [2:0] cmd, input logic [31:0] addr,
                       input logic [LABEL_W-1:0] lbl);
        sta_req_t req;
        req               = random_req();
        req.command       = cmd;
        req.query_address = addr;
        req.query_label   = lbl;
        send_req(req);
    endtask

    task automatic write_count(input logic [7:0] n);
        cfg_data      <= n;
        cfg_valid     <= 1'b1;
        section_count  = n;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // drain every result before the count may change
    task automatic settle();
        s_valid <= 1'b0;
        while (rsp_outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(99, 0);
        if (r < 22)
            write_random_entry(7'($urandom_range(MAX_SECTIONS - 1, 0)));
        else if (r < 46)
            ask(CMD_V2O, aim_address(sh_virt[live_slot()]), {$urandom, $urandom});
        else if (r < 68)
            ask(CMD_O2V, aim_address(sh_off[live_slot()]), {$urandom, $urandom});
        else if (r < 84)
            ask(CMD_NAME, $urandom, aim_label());
        else if (r < 95)
            ask(CMD_SIZE, $urandom, {$urandom, $urandom});
        else
            ask(3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST)), $urandom,
                {$urandom, $urandom});
    endtask

    function automatic logic [7:0] phase_count(input int p);
        case (p)
            0:       return 8'd128;
            1:       return 8'd255;
            2:       return 8'd1;
            3:       return 8'd0;
            4:       return 8'd129;
            6:       return 8'd64;
            7:       return 8'd200;
            8:       return 8'd2;
            9:       return 8'($urandom_range(8, 1));
            10:      return 8'd127;
            default: return 8'($urandom_range(255, 0));
        endcase
    endfunction

    initial begin
        int order [MAX_SECTIONS];
        int j;
        int t;

        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_payload      = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        section_count  = '0;
        label_pool[0]  = '0;
        label_pool[1]  = '1;
        for (int i = 2; i < LABEL_POOL; i++) label_pool[i] = {$urandom, $urandom};
        for (int i = 0; i < MAX_SECTIONS; i++) begin
            sh_virt[i]  = '0;
            sh_off[i]   = '0;
            sh_label[i] = '0;
            order[i]    = i;
        end

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty table: misses, pass-through and zero image size
        write_count(8'd0);
        ask(CMD_V2O, 32'hFFFF_FFFF, '0);
        ask(CMD_O2V, 32'h0, '1);
        ask(CMD_NAME, 32'h0, '0);
        ask(CMD_SIZE, 32'hFFFF_FFFF, '1);
        for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++) ask(3'(c), $urandom, '1);

        // zero-size entry, wrapping entry, equal offsets and a duplicate name
        put_entry(7'd0, 32'h0, 32'h0, 32'h0, '0);
        put_entry(7'd1, 32'hFFFF_F000, 32'hFFFF_FFF0, 32'hFFFF_FFFF, '1);
        put_entry(7'd2, 32'h0000_1000, 32'hFFFF_FFF0, 32'h0000_0200, '1);
        put_entry(7'd127, $urandom, $urandom, $urandom, {$urandom, $urandom});
        settle();

        write_count(8'd3);
        ask(CMD_V2O, 32'h0, '0);
        ask(CMD_V2O, 32'hFFFF_FFFF, '0);
        ask(CMD_V2O, 32'h0000_1000, '0);
        ask(CMD_O2V, 32'h0, '0);
        ask(CMD_O2V, 32'hFFFF_FFFF, '0);
        ask(CMD_NAME, 32'h0, '1);
        ask(CMD_NAME, 32'h0, '0);
        ask(CMD_NAME, 32'h0, {$urandom, $urandom});
        ask(CMD_SIZE, 32'h0, '0);
        settle();

        // load every slot in shuffled order so any count is legal afterwards
        send_idle_pct  = 19;
        recv_stall_pct = 19;
        for (int i = MAX_SECTIONS - 1; i > 0; i--) begin
            j        = $urandom_range(i, 0);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < MAX_SECTIONS; i++) write_random_entry(7'(order[i]));
        settle();

        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            write_count(phase_count(p));
            repeat (ITEMS_PER_PHASE) random_item();
            settle();
        end

        repeat (20) @(posedge aclk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
